FILE: rtl/fnh_pkg.sv
// fnh_pkg: shared types, constants and helper functions of the family name hash
package fnh_pkg;

  localparam int unsigned CaptureDepthDefault = 16;

  localparam logic [31:0] FnvBasis = 32'h811c9dc5;
  localparam logic [31:0] FnvPrime = 32'h01000193;

  localparam int unsigned GenCount = 12;
  localparam int unsigned NameMax  = 13;

  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChDquote = 8'h22;
  localparam logic [7:0] ChSquote = 8'h27;

  // one queued item, already classified by the front
  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       last;
    logic       is_ws;
  } item_t;

  typedef enum logic [2:0] {
    BkIdle,
    BkSpace,
    BkByte,
    BkEnd,
    BkFetch,
    BkCmp,
    BkOut
  } back_state_e;

  function automatic logic is_ws(input logic [7:0] b);
    return (b == ChSpace) || (b >= 8'h09 && b <= 8'h0d);
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] b);
    return (b >= 8'h41 && b <= 8'h5a) ? b + 8'h20 : b;
  endfunction

  function automatic logic is_quote(input logic [7:0] b);
    return (b == ChDquote) || (b == ChSquote);
  endfunction

  // 32-bit product only, the upper half is never needed
  function automatic logic [31:0] fnv_mix(input logic [31:0] h, input logic [7:0] c);
    logic [31:0] x;
    x = h ^ {24'h000000, c};
    return x * FnvPrime;
  endfunction

  // generic family names, right-aligned in a fixed-width string
  function automatic logic [NameMax*8-1:0] gen_name(input logic [3:0] k);
    logic [NameMax*8-1:0] nm;
    case (k)
      4'd0:    nm = "serif";
      4'd1:    nm = "sans-serif";
      4'd2:    nm = "monospace";
      4'd3:    nm = "cursive";
      4'd4:    nm = "fantasy";
      4'd5:    nm = "system-ui";
      4'd6:    nm = "ui-serif";
      4'd7:    nm = "ui-sans-serif";
      4'd8:    nm = "ui-monospace";
      4'd9:    nm = "emoji";
      4'd10:   nm = "math";
      4'd11:   nm = "fangsong";
      default: nm = '0;
    endcase
    return nm;
  endfunction

  function automatic logic [3:0] gen_len(input logic [3:0] k);
    logic [3:0] len;
    case (k)
      4'd0:    len = 4'd5;
      4'd1:    len = 4'd10;
      4'd2:    len = 4'd9;
      4'd3:    len = 4'd7;
      4'd4:    len = 4'd7;
      4'd5:    len = 4'd9;
      4'd6:    len = 4'd8;
      4'd7:    len = 4'd13;
      4'd8:    len = 4'd12;
      4'd9:    len = 4'd5;
      4'd10:   len = 4'd4;
      4'd11:   len = 4'd8;
      default: len = 4'd0;
    endcase
    return len;
  endfunction

  function automatic logic [7:0] gen_char(input logic [3:0] k, input logic [3:0] j);
    logic [NameMax*8-1:0] nm;
    logic [NameMax*8-1:0] sh;
    logic [3:0]           len;
    logic [3:0]           pos;
    nm  = gen_name(k);
    len = gen_len(k);
    pos = len - j - 4'd1;
    sh  = nm >> {pos, 3'b000};
    return (j < len) ? sh[7:0] : 8'h00;
  endfunction

endpackage

FILE: rtl/fnh_ram.sv
// fnh_ram: generic single-write, registered-read memory
module fnh_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/fnh_front.sv
// fnh_front: input handshake, drops empty non-final items and tags whitespace
module fnh_front (
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [7:0]    data_byte_i,
  input  logic          byte_present_i,
  input  logic          last_i,
  output logic          push_valid_o,
  input  logic          push_ready_i,
  output fnh_pkg::item_t push_item_o
);

  // an absent byte that does not end the name has no effect
  assign in_ready_o   = push_ready_i;
  assign push_valid_o = in_valid_i && (byte_present_i || last_i);

  always_comb begin
    push_item_o.data_byte    = data_byte_i;
    push_item_o.byte_present = byte_present_i;
    push_item_o.last         = last_i;
    push_item_o.is_ws        = byte_present_i && fnh_pkg::is_ws(data_byte_i);
  end

endmodule

FILE: rtl/fnh_fifo.sv
// fnh_fifo: two-entry item queue between front and back
module fnh_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  fnh_pkg::item_t push_item_i,
  output logic           pop_valid_o,
  input  logic           pop_i,
  output fnh_pkg::item_t pop_item_o
);

  fnh_pkg::item_t slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_item_o   = slot_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

FILE: rtl/fnh_back.sv
// fnh_back: hashing sequencer, name capture and generic-name walk
module fnh_back #(
  parameter int unsigned CaptureDepth = fnh_pkg::CaptureDepthDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           item_valid_i,
  input  fnh_pkg::item_t item_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [31:0]    family_hash_o,
  output logic           is_generic_o
);

  localparam int unsigned AW = $clog2(CaptureDepth);
  localparam int unsigned LW = $clog2(CaptureDepth + 1);
  localparam int unsigned MW = $clog2(CaptureDepth + 3);
  localparam int unsigned GC = fnh_pkg::GenCount;

  fnh_pkg::back_state_e state_q, state_d;

  logic [31:0]   plain_q, plain_d, inner_q, inner_d, before_q, before_d;
  logic          plain_wrote_q, plain_wrote_d;
  logic [1:0]    iwf_q, iwf_d, pend_q, pend_d;
  logic [7:0]    first_q, first_d, lastb_q, lastb_d, prev_q, prev_d;
  logic [7:0]    head0_q, head0_d, head1_q, head1_d, byte_q, byte_d;
  logic [1:0]    count_q, count_d;
  logic          head_gap_q, head_gap_d, gap_seen_q, gap_seen_d;
  logic [LW-1:0] cap_len_q, cap_len_d;
  logic          ovf_q, ovf_d;
  logic          sp_plain_q, sp_plain_d, sp_inner_q, sp_inner_d;
  logic          do_inner_q, do_inner_d, end_q, end_d;
  logic [1:0]    strip_q, strip_d;
  logic [3:0]    len_q, len_d, j_q, j_d;
  logic [GC-1:0] cand_q, cand_d;
  logic [31:0]   hash_q, hash_d;
  logic          gen_q, gen_d;
  logic          out_valid_q, out_valid_d, out_gen_q, out_gen_d;
  logic [31:0]   out_hash_q, out_hash_d;

  // end-of-name classification
  logic [MW-1:0] m_len, l_len;
  logic          strip1, strip2, walk_ok;
  // walk datapath
  logic [4:0]    idx;
  logic [7:0]    cur_c;
  logic          cur_gap;
  logic [3:0]    j_inc;
  logic [GC-1:0] cand_nx, len_hit;
  logic          out_free;
  // memory port
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [8:0]    ram_wdata, ram_rdata;

  fnh_ram #(
    .Width(9),
    .Depth(CaptureDepth)
  ) u_capture (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    m_len   = MW'(count_q) + MW'(cap_len_q);
    strip1  = (count_q == 2'd2) && (first_q == lastb_q) && fnh_pkg::is_quote(first_q);
    strip2  = strip1 && (m_len >= MW'(4)) && (head1_q == prev_q) &&
              fnh_pkg::is_quote(head1_q);
    l_len   = m_len - MW'({strip1 & strip2, strip1 ^ strip2, 1'b0});
    walk_ok = (count_q != 2'd0) && !ovf_q && (l_len != '0) &&
              (l_len <= MW'(fnh_pkg::NameMax));
  end

  always_comb begin
    idx     = {3'b000, strip_q} + {1'b0, j_q};
    cur_c   = (idx == 5'd0) ? head0_q : (idx == 5'd1) ? head1_q : ram_rdata[7:0];
    cur_gap = (j_q == 4'd0) ? 1'b0 : (idx == 5'd1) ? head_gap_q : ram_rdata[8];
    j_inc   = j_q + 4'd1;
    for (int k = 0; k < GC; k++) begin
      cand_nx[k] = cand_q[k] && !cur_gap && (j_q < fnh_pkg::gen_len(4'(k))) &&
                   (fnh_pkg::to_lower(cur_c) == fnh_pkg::gen_char(4'(k), j_q));
      len_hit[k] = (fnh_pkg::gen_len(4'(k)) == len_q);
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      fnh_pkg::BkIdle: begin
        if (item_valid_i) begin
          if (item_i.byte_present && !item_i.is_ws) begin
            state_d = ((pend_q[0]) || (pend_q[1] && count_q != 2'd0)) ?
                      fnh_pkg::BkSpace : fnh_pkg::BkByte;
          end else if (item_i.last) begin
            state_d = fnh_pkg::BkEnd;
          end
        end
      end
      fnh_pkg::BkSpace: state_d = fnh_pkg::BkByte;
      fnh_pkg::BkByte:  state_d = end_q ? fnh_pkg::BkEnd : fnh_pkg::BkIdle;
      fnh_pkg::BkEnd:   state_d = walk_ok ? fnh_pkg::BkFetch : fnh_pkg::BkOut;
      fnh_pkg::BkFetch: state_d = fnh_pkg::BkCmp;
      fnh_pkg::BkCmp:   state_d = (j_inc == len_q) ? fnh_pkg::BkOut : fnh_pkg::BkFetch;
      fnh_pkg::BkOut:   state_d = out_free ? fnh_pkg::BkIdle : fnh_pkg::BkOut;
      default:          state_d = fnh_pkg::BkIdle;
    endcase
  end

  // control outputs
  always_comb begin
    pop_o     = (state_q == fnh_pkg::BkIdle) && item_valid_i;
    ram_we    = pop_o && item_i.byte_present && !item_i.is_ws && (count_q == 2'd2) &&
                (cap_len_q < LW'(CaptureDepth));
    ram_waddr = cap_len_q[AW-1:0];
    ram_wdata = {gap_seen_q, item_i.data_byte};
    ram_re    = (state_q == fnh_pkg::BkFetch);
    ram_raddr = AW'(idx - 5'd2);
  end

  // datapath
  always_comb begin
    plain_d       = plain_q;
    inner_d       = inner_q;
    before_d      = before_q;
    plain_wrote_d = plain_wrote_q;
    iwf_d         = iwf_q;
    pend_d        = pend_q;
    first_d       = first_q;
    lastb_d       = lastb_q;
    prev_d        = prev_q;
    head0_d       = head0_q;
    head1_d       = head1_q;
    byte_d        = byte_q;
    count_d       = count_q;
    head_gap_d    = head_gap_q;
    gap_seen_d    = gap_seen_q;
    cap_len_d     = cap_len_q;
    ovf_d         = ovf_q;
    sp_plain_d    = sp_plain_q;
    sp_inner_d    = sp_inner_q;
    do_inner_d    = do_inner_q;
    end_d         = end_q;
    strip_d       = strip_q;
    len_d         = len_q;
    j_d           = j_q;
    cand_d        = cand_q;
    hash_d        = hash_q;
    gen_d         = gen_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    out_hash_d    = out_hash_q;
    out_gen_d     = out_gen_q;

    case (state_q)
      fnh_pkg::BkIdle: begin
        if (item_valid_i && item_i.byte_present) begin
          if (item_i.is_ws) begin
            pend_d     = pend_q | {iwf_q[0], plain_wrote_q};
            gap_seen_d = 1'b1;
          end else begin
            byte_d        = fnh_pkg::to_lower(item_i.data_byte);
            end_d         = item_i.last;
            sp_plain_d    = pend_q[0];
            sp_inner_d    = pend_q[1] && (count_q != 2'd0);
            do_inner_d    = (count_q != 2'd0);
            plain_wrote_d = 1'b1;
            if (count_q != 2'd0) begin
              before_d = inner_q;
              iwf_d    = iwf_q[0] ? 2'b11 : 2'b01;
            end
            pend_d     = 2'b00;
            gap_seen_d = 1'b0;
            prev_d     = lastb_q;
            lastb_d    = item_i.data_byte;
            case (count_q)
              2'd0: begin
                head0_d = item_i.data_byte;
                first_d = item_i.data_byte;
              end
              2'd1: begin
                head1_d    = item_i.data_byte;
                head_gap_d = gap_seen_q;
              end
              default: begin
                if (cap_len_q < LW'(CaptureDepth)) begin
                  cap_len_d = cap_len_q + LW'(1);
                end else begin
                  ovf_d = 1'b1;
                end
              end
            endcase
            if (count_q != 2'd2) begin
              count_d = count_q + 2'd1;
            end
          end
        end
      end
      fnh_pkg::BkSpace: begin
        if (sp_plain_q) plain_d = fnh_pkg::fnv_mix(plain_q, fnh_pkg::ChSpace);
        if (sp_inner_q) inner_d = fnh_pkg::fnv_mix(inner_q, fnh_pkg::ChSpace);
      end
      fnh_pkg::BkByte: begin
        plain_d = fnh_pkg::fnv_mix(plain_q, byte_q);
        if (do_inner_q) inner_d = fnh_pkg::fnv_mix(inner_q, byte_q);
      end
      fnh_pkg::BkEnd: begin
        if (count_q == 2'd0) begin
          hash_d = 32'h0;
        end else if (strip1) begin
          hash_d = iwf_q[1] ? before_q : 32'h0;
        end else begin
          hash_d = plain_wrote_q ? plain_q : 32'h0;
        end
        strip_d = {strip1 & strip2, strip1 ^ strip2};
        len_d   = l_len[3:0];
        j_d     = 4'd0;
        cand_d  = '1;
        gen_d   = 1'b0;
      end
      fnh_pkg::BkFetch: begin
      end
      fnh_pkg::BkCmp: begin
        cand_d = cand_nx;
        j_d    = j_inc;
        gen_d  = |(cand_nx & len_hit);
      end
      fnh_pkg::BkOut: begin
        if (out_free) begin
          out_valid_d   = 1'b1;
          out_hash_d    = gen_q ? 32'h0 : hash_q;
          out_gen_d     = gen_q;
          // back to an empty name
          plain_d       = fnh_pkg::FnvBasis;
          inner_d       = fnh_pkg::FnvBasis;
          before_d      = fnh_pkg::FnvBasis;
          plain_wrote_d = 1'b0;
          iwf_d         = 2'b00;
          pend_d        = 2'b00;
          count_d       = 2'd0;
          head_gap_d    = 1'b0;
          gap_seen_d    = 1'b0;
          cap_len_d     = '0;
          ovf_d         = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= fnh_pkg::BkIdle;
      plain_q       <= fnh_pkg::FnvBasis;
      inner_q       <= fnh_pkg::FnvBasis;
      before_q      <= fnh_pkg::FnvBasis;
      plain_wrote_q <= 1'b0;
      iwf_q         <= 2'b00;
      pend_q        <= 2'b00;
      count_q       <= 2'd0;
      head_gap_q    <= 1'b0;
      gap_seen_q    <= 1'b0;
      cap_len_q     <= '0;
      ovf_q         <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      plain_q       <= plain_d;
      inner_q       <= inner_d;
      before_q      <= before_d;
      plain_wrote_q <= plain_wrote_d;
      iwf_q         <= iwf_d;
      pend_q        <= pend_d;
      count_q       <= count_d;
      head_gap_q    <= head_gap_d;
      gap_seen_q    <= gap_seen_d;
      cap_len_q     <= cap_len_d;
      ovf_q         <= ovf_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    first_q    <= first_d;
    lastb_q    <= lastb_d;
    prev_q     <= prev_d;
    head0_q    <= head0_d;
    head1_q    <= head1_d;
    byte_q     <= byte_d;
    sp_plain_q <= sp_plain_d;
    sp_inner_q <= sp_inner_d;
    do_inner_q <= do_inner_d;
    end_q      <= end_d;
    strip_q    <= strip_d;
    len_q      <= len_d;
    j_q        <= j_d;
    cand_q     <= cand_d;
    hash_q     <= hash_d;
    gen_q      <= gen_d;
    out_hash_q <= out_hash_d;
    out_gen_q  <= out_gen_d;
  end

  assign out_valid_o   = out_valid_q;
  assign family_hash_o = out_hash_q;
  assign is_generic_o  = out_gen_q;

endmodule

FILE: rtl/font_family_name_hash.sv
// font_family_name_hash: top level of the normalized font family name hasher
//
//   channel | direction | handshake             | payload
//   in      | into blk  | in_valid_i/in_ready_o | data_byte_i, byte_present_i, last_i
//   out     | from blk  | out_valid_o/out_ready_i | family_hash_o, is_generic_o
//
// back end: a whitespace byte is taken in the idle state alone, a visible byte also passes
//   the byte state, after the space state when a collapsed space is hashed first
// end of name: the end state classifies, the fetch and compare states walk the stripped
//   name (at most 13 characters) over the capture ram, and the out state sends the result
// reset: asynchronous, active low; no clearing pass, capture ram data is only used
//   where it was written for the current name
// stalls: a two-entry queue lets the front take up to two items while the back end works
//   or waits on out_ready_i; the result sits in an output register
module font_family_name_hash #(
  parameter int unsigned CaptureDepth = fnh_pkg::CaptureDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        byte_present_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] family_hash_o,
  output logic        is_generic_o
);

  logic           push_valid, push_ready;
  fnh_pkg::item_t push_item;
  logic           pop_valid, pop;
  fnh_pkg::item_t pop_item;

  // front: handshake and whitespace tagging
  fnh_front u_front (
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .data_byte_i   (data_byte_i),
    .byte_present_i(byte_present_i),
    .last_i        (last_i),
    .push_valid_o  (push_valid),
    .push_ready_i  (push_ready),
    .push_item_o   (push_item)
  );

  // decoupling queue
  fnh_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_ready_o(push_ready),
    .push_item_i (push_item),
    .pop_valid_o (pop_valid),
    .pop_i       (pop),
    .pop_item_o  (pop_item)
  );

  // back: hashing, capture and generic match
  fnh_back #(
    .CaptureDepth(CaptureDepth)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (pop_valid),
    .item_i       (pop_item),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .family_hash_o(family_hash_o),
    .is_generic_o (is_generic_o)
  );

endmodule

FILE: rtl/fnh_checker.sv
// fnh_checker: port-level assertions for the family name hasher, bound to the top
module fnh_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [7:0]  data_byte_i,
  input logic        byte_present_i,
  input logic        last_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] family_hash_o,
  input logic        is_generic_o
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(family_hash_o) &&
    $stable(is_generic_o))
    else $error("stalled result changed");

  // generic names always hash to zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_generic_o |-> family_hash_o == 32'h0)
    else $error("generic name with nonzero hash");

  // no result right out of reset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result valid right after reset");

  // a result valid rises only after a sample in which it was low
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!out_valid_o))
    else $error("result valid rose without a prior idle cycle");

endmodule

bind font_family_name_hash fnh_checker u_fnh_checker (.*);

FILE: tb/font_family_name_hash_test.sv
// font_family_name_hash_test: self-checking testbench of the font family name hasher
module font_family_name_hash_test;

  localparam logic [31:0] HashBasis = 32'h811c9dc5;
  localparam logic [31:0] HashPrime = 32'h01000193;
  localparam int          CapDepth  = 16;
  localparam int          StallMax  = 20000;

  // expected result of one name
  typedef struct {
    logic [31:0] family_hash;
    logic        is_generic;
  } name_result_t;

  // running normalizer and hasher, plus the store of expected results
  class name_hash_board;
    logic [31:0]  plain_h, inner_h, inner_prev;
    bit           plain_wrote, inner_now, inner_before, pend_plain, pend_inner;
    logic [7:0]   first_b, last_b;
    int           nonspace;
    logic [7:0]   raw[$];      // raw bytes of the current name for the generic match
    name_result_t pending[$];
    int           errors;

    function new();
      errors = 0;
      clear();
    endfunction

    function void clear();
      plain_h = HashBasis; inner_h = HashBasis; inner_prev = HashBasis;
      plain_wrote = 0; inner_now = 0; inner_before = 0;
      pend_plain = 0; pend_inner = 0; nonspace = 0;
      first_b = 0; last_b = 0;
      raw.delete();
    endfunction

    function bit ws(logic [7:0] b);
      return b == 8'h20 || (b >= 8'h09 && b <= 8'h0d);
    endfunction

    function logic [7:0] lc(logic [7:0] b);
      return (b >= 8'h41 && b <= 8'h5a) ? b + 8'h20 : b;
    endfunction

    function logic [31:0] mix(logic [31:0] h, logic [7:0] b);
      return (h ^ {24'h0, b}) * HashPrime;
    endfunction

    // trim, then drop one matching outer quote pair and trim again
    function void peel(ref logic [7:0] s[$]);
      while (s.size() > 0 && ws(s[0])) void'(s.pop_front());
      while (s.size() > 0 && ws(s[s.size()-1])) void'(s.pop_back());
      if (s.size() >= 2 && s[0] == s[s.size()-1] && (s[0] == 8'h22 || s[0] == 8'h27)) begin
        void'(s.pop_front());
        void'(s.pop_back());
        while (s.size() > 0 && ws(s[0])) void'(s.pop_front());
        while (s.size() > 0 && ws(s[s.size()-1])) void'(s.pop_back());
      end
    endfunction

    function bit generic_name();
      string        names[12];
      logic [7:0]   s[$];
      int           nonsp;
      bit           gap;
      bit           ok;
      names = '{"serif", "sans-serif", "monospace", "cursive", "fantasy", "system-ui",
                "ui-serif", "ui-sans-serif", "ui-monospace", "emoji", "math", "fangsong"};
      nonsp = 0;
      gap = 0;
      // rebuild with inner runs as one space, as the block keeps it
      foreach (raw[i]) begin
        if (ws(raw[i])) gap = 1;
        else begin
          if (gap && nonsp > 0) s.push_back(8'h20);
          s.push_back(raw[i]);
          nonsp++;
          gap = 0;
        end
      end
      if (nonsp > CapDepth + 2) return 0;
      peel(s);
      peel(s);
      foreach (names[k]) begin
        ok = (s.size() == names[k].len());
        for (int j = 0; ok && j < s.size(); j++) if (lc(s[j]) != names[k][j]) ok = 0;
        if (ok) return 1;
      end
      return 0;
    endfunction

    function void take_item(logic [7:0] b, bit present, bit last);
      name_result_t r;
      logic [7:0]   l;
      if (present) begin
        raw.push_back(b);
        if (ws(b)) begin
          if (plain_wrote) pend_plain = 1;
          if (inner_now) pend_inner = 1;
        end else begin
          l = lc(b);
          if (pend_plain) plain_h = mix(plain_h, 8'h20);
          plain_h = mix(plain_h, l);
          plain_wrote = 1;
          if (nonspace > 0) begin
            inner_prev = inner_h;
            inner_before = inner_now;
            if (pend_inner) inner_h = mix(inner_h, 8'h20);
            inner_h = mix(inner_h, l);
            inner_now = 1;
          end else first_b = b;
          pend_plain = 0;
          pend_inner = 0;
          last_b = b;
          nonspace++;
        end
      end
      if (!last) return;
      r.family_hash = 0;
      r.is_generic = 0;
      if (nonspace > 0) begin
        if (nonspace >= 2 && first_b == last_b && (first_b == 8'h22 || first_b == 8'h27))
          r.family_hash = inner_before ? inner_prev : 32'h0;
        else
          r.family_hash = plain_h;
        r.is_generic = generic_name();
        if (r.is_generic) r.family_hash = 0;
      end
      pending.push_back(r);
      clear();
    endfunction

    function void check_result(logic [31:0] h, logic g);
      name_result_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result hash=%h generic=%b", h, g);
        return;
      end
      e = pending.pop_front();
      if (h !== e.family_hash || g !== e.is_generic) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: hash exp %h got %h, generic exp %b got %b",
                   e.family_hash, h, e.is_generic, g);
      end
    endfunction
  endclass

  logic        clk_i, rst_ni;
  logic        in_valid_i, in_ready_o;
  logic [7:0]  data_byte_i;
  logic        byte_present_i, last_i;
  logic        out_valid_o, out_ready_i;
  logic [31:0] family_hash_o;
  logic        is_generic_o;

  name_hash_board board;
  int          items_sent;
  int          idle_count;
  bit          calm;        // no idling in the final stretch
  bit          hold_out;    // receiver holds off for a long stretch

  font_family_name_hash uut (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_o, .data_byte_i, .byte_present_i, .last_i,
    .out_valid_o, .out_ready_i, .family_hash_o, .is_generic_o
  );

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  // one item: wait out a possible sender gap, offer it, hold until it is taken
  task automatic send_item(logic [7:0] b, bit present, bit last);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    in_valid_i     <= 1;
    data_byte_i    <= b;
    byte_present_i <= present;
    last_i         <= last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    board.take_item(b, present, last);
    items_sent++;
  endtask

  task automatic send_name(string s);
    if (s.len() == 0) send_item(8'h00, 0, 1);
    else for (int i = 0; i < s.len(); i++) send_item(s[i], 1, i == s.len() - 1);
  endtask

  // random byte biased toward whitespace, quotes and letters
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0:       return 8'h20;
      1:       return 8'($urandom_range(9, 13));
      2:       return $urandom_range(0, 1) ? 8'h22 : 8'h27;
      3:       return 8'($urandom_range(0, 255));
      4, 5:    return 8'($urandom_range(8'h41, 8'h5a));
      default: return 8'($urandom_range(8'h61, 8'h7a));
    endcase
  endfunction

  function automatic string case_mix(string s);
    string r;
    r = s;
    for (int i = 0; i < r.len(); i++)
      if (r[i] >= "a" && r[i] <= "z" && $urandom_range(0, 1)) r[i] = r[i] - 8'h20;
    return r;
  endfunction

  function automatic string ws_str();
    string r;
    string pool;
    pool = " \t\n\v\f\r";
    r = "";
    repeat ($urandom_range(0, 2)) r = {r, string'(pool[$urandom_range(0, 5)])};
    return r;
  endfunction

  // generic name, maybe wrapped in up to three quote layers, with random padding
  function automatic string wrapped_generic();
    string names[12];
    string s;
    string q;
    names = '{"serif", "sans-serif", "monospace", "cursive", "fantasy", "system-ui",
              "ui-serif", "ui-sans-serif", "ui-monospace", "emoji", "math", "fangsong"};
    s = case_mix(names[$urandom_range(0, 11)]);
    repeat ($urandom_range(0, 3)) begin
      q = $urandom_range(0, 1) ? "\"" : "'";
      s = {ws_str(), q, ws_str(), s, ws_str(), q, ws_str()};
    end
    if ($urandom_range(0, 5) == 0) s[$urandom_range(0, s.len() - 1)] = pick_byte();
    return s;
  endfunction

  task automatic random_name();
    int n;
    int kind;
    kind = $urandom_range(0, 9);
    if (kind < 3) send_name(wrapped_generic());
    else begin
      n = (kind == 9) ? $urandom_range(17, 40) : $urandom_range(1, 12);
      for (int i = 0; i < n; i++) begin
        // absent bytes in the middle are ignored
        if ($urandom_range(0, 15) == 0) send_item(pick_byte(), 0, 0);
        send_item(pick_byte(), 1, 0);
      end
      send_item(pick_byte(), $urandom_range(0, 3) != 0, 1);
    end
  endtask

  // receiver: random stall bursts, a long hold when asked, none at the end
  initial begin
    out_ready_i <= 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) board.check_result(family_hash_o, is_generic_o);
      if (hold_out) begin
        out_ready_i <= 0;
        repeat (300) @(posedge clk_i);
        hold_out = 0;
        out_ready_i <= 1;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        out_ready_i <= 0;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
        out_ready_i <= 1;
      end else out_ready_i <= 1;
    end
  end

  // watchdog on cycles without any accepted item or result
  initial begin
    idle_count = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_count = 0;
      else idle_count++;
      if (idle_count >= StallMax) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    board = new();
    items_sent = 0;
    calm = 0;
    hold_out = 0;
    rst_ni <= 0;
    in_valid_i <= 0;
    data_byte_i <= 0;
    byte_present_i <= 0;
    last_i <= 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: empty, blank, quotes, generics, extremes
    send_name("");
    send_name(" \t\r\n\v\f ");
    send_name("Arial");
    send_name("  Times   New\tRoman ");
    send_name("\"\"");
    send_name("' '");
    send_name("\"a\"");
    send_name("\"SERIF\"");
    send_name(" ' \"Sans-Serif\" ' ");
    send_name("\"'\"monospace\"'\"");
    send_name("'x\"");
    send_item(8'hff, 1, 0);
    send_item(8'h00, 1, 0);
    send_item(8'h80, 0, 0);
    send_item(8'h7f, 1, 1);
    send_name("abcdefghijklmnopqrstuvwxyz0123456789");
    send_name("ui-sans-serifx");

    // receiver holds off while names keep coming, so the block backs up
    hold_out = 1;
    repeat (8) random_name();
    while (hold_out) @(posedge clk_i);

    // sender pauses until every expected result has come
    in_valid_i <= 0;
    while (board.pending.size() != 0) @(posedge clk_i);

    while (items_sent < 1400) random_name();
    calm = 1;
    while (items_sent < 1550) random_name();
    in_valid_i <= 0;

    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (board.errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

FILE: files.f
rtl/fnh_pkg.sv
rtl/fnh_ram.sv
rtl/fnh_front.sv
rtl/fnh_fifo.sv
rtl/fnh_back.sv
rtl/font_family_name_hash.sv
rtl/fnh_checker.sv
tb/font_family_name_hash_test.sv
